// ----- src/iirdf1_pkg.sv -----
// Shared types, widths and register indexes of the direct-form I IIR filter.
package iirdf1_pkg;

  localparam int unsigned SampleW   = 16;   // input and output samples
  localparam int unsigned CoefW     = 32;   // Q8.24 coefficient
  localparam int unsigned HistW     = 32;   // Q16.16 fed-back output
  localparam int unsigned ProdW     = CoefW + HistW;
  localparam int unsigned BProdW    = CoefW + SampleW;
  localparam int unsigned BShift    = 16;   // aligns b*x to Q.40
  localparam int unsigned AccW      = 72;   // holds 15 Q.40 terms exactly
  localparam int unsigned YShift    = 24;   // Q.40 -> Q16.16
  localparam int unsigned RShift    = 40;   // Q.40 -> integer
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned NumCoefs  = 8;    // b0..b7, a1..a7
  localparam int unsigned CoefIdxW  = 3;
  localparam int unsigned OrderDefault = 4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegBCoef01 = 4'd0;
  localparam logic [CfgIdxW-1:0] RegBCoef23 = 4'd1;
  localparam logic [CfgIdxW-1:0] RegBCoef45 = 4'd2;
  localparam logic [CfgIdxW-1:0] RegBCoef67 = 4'd3;
  localparam logic [CfgIdxW-1:0] RegACoef12 = 4'd4;
  localparam logic [CfgIdxW-1:0] RegACoef34 = 4'd5;
  localparam logic [CfgIdxW-1:0] RegACoef56 = 4'd6;
  localparam logic [CfgIdxW-1:0] RegACoef7  = 4'd7;

  typedef enum logic [1:0] {
    StIdle,
    StMac,
    StDrain,
    StRound
  } state_e;

  typedef struct packed {
    logic rotate;   // take the pair from the next cell up the ring
    logic shift;    // take the pair from the previous cell (new sample at the head)
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;    // zero the accumulator
    logic issue;    // start a product this cycle
    logic is_a;     // product is a feedback term (subtract, no alignment)
  } mac_ctrl_t;

endpackage

// ----- src/iirdf1_cell.sv -----
// One delay cell of the history ring: one past input and one past output.
module iirdf1_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  iirdf1_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [iirdf1_pkg::SampleW-1:0]  rot_x_i,
  input  logic signed [iirdf1_pkg::HistW-1:0]    rot_y_i,
  input  logic signed [iirdf1_pkg::SampleW-1:0]  sh_x_i,
  input  logic signed [iirdf1_pkg::HistW-1:0]    sh_y_i,
  output logic signed [iirdf1_pkg::SampleW-1:0]  x_o,
  output logic signed [iirdf1_pkg::HistW-1:0]    y_o
);
  import iirdf1_pkg::*;

  logic signed [SampleW-1:0] x_q, x_d;
  logic signed [HistW-1:0]   y_q, y_d;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (ctrl_i.shift) begin
      x_d = sh_x_i;
      y_d = sh_y_i;
    end else if (ctrl_i.rotate) begin
      x_d = rot_x_i;
      y_d = rot_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ----- src/iirdf1_mac.sv -----
// Shared multiply-accumulate unit: one registered product a cycle into a Q.40 accumulator.
module iirdf1_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  iirdf1_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [iirdf1_pkg::CoefW-1:0]  coef_i,
  input  logic signed [iirdf1_pkg::HistW-1:0]  opnd_i,
  output logic signed [iirdf1_pkg::AccW-1:0]   acc_o
);
  import iirdf1_pkg::*;

  logic signed [ProdW-1:0] prod_q, prod_d;
  logic                    pvalid_q, pis_a_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  term_b, term_a;

  assign prod_d = coef_i * opnd_i;

  // b*x fits in BProdW bits; align it up to Q.40. a*y is already Q.40.
  assign term_b = {{(AccW-BProdW-BShift){prod_q[BProdW-1]}}, prod_q[BProdW-1:0],
                   {BShift{1'b0}}};
  assign term_a = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (pvalid_q) begin
      acc_d = pis_a_q ? (acc_q - term_a) : (acc_q + term_b);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
      pis_a_q  <= 1'b0;
      acc_q    <= '0;
    end else begin
      pvalid_q <= ctrl_i.issue;
      pis_a_q  <= ctrl_i.is_a;
      acc_q    <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- src/iir_direct_form_one_filter.sv -----
// Direct-form I IIR filter: a ring of history cells feeding one shared MAC.
// An accepted item passes through StMac, StDrain and StRound; StRound loads the output register.
// A new item is accepted only in StIdle, once the last one is done, since the single multiplier
//   takes the 2*ORDER+1 products of one item one after the other.
// Reset (rst_ni low, asynchronous) zeroes coefficients and histories and empties the output.
// No clearing pass: the block comes out of reset in StIdle, ready to accept an item.
module iir_direct_form_one_filter #(
  parameter int unsigned ORDER = iirdf1_pkg::OrderDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input item stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [iirdf1_pkg::SampleW-1:0]        s_axis_tdata,   // [15:0] sample
  // result item stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [iirdf1_pkg::SampleW-1:0]        m_axis_tdata,   // [15:0] filtered
  output logic                                  m_axis_tuser,   // [0] saturated
  // coefficient write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [iirdf1_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [iirdf1_pkg::CfgDataW-1:0]       cfg_data_i
);
  import iirdf1_pkg::*;

  localparam int unsigned NumSteps = 2 * ORDER + 1;
  localparam int unsigned StepW    = $clog2(NumSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(2 * ORDER);

  // ------------------------------------------------------------------
  // Coefficient registers. Two Q8.24 values per register, lower index low.
  // ------------------------------------------------------------------
  logic [CfgDataW-1:0] coef_q [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumRegs; k++) coef_q[k] <= '0;
    end else if (cfg_valid_i) begin
      // Drop writes beyond the register list; the last register is one coefficient wide.
      if (cfg_index_i == RegACoef7) begin
        coef_q[RegACoef7[CoefIdxW-1:0]] <= {{(CfgDataW-CoefW){1'b0}}, cfg_data_i[CoefW-1:0]};
      end else if (cfg_index_i < RegACoef7) begin
        coef_q[cfg_index_i[CoefIdxW-1:0]] <= cfg_data_i;
      end
    end
  end

  // Unpack into coefficient tables; a_tab[0] is unused (a0 is one by convention).
  logic signed [CoefW-1:0] b_tab [NumCoefs];
  logic signed [CoefW-1:0] a_tab [NumCoefs];

  always_comb begin
    for (int j = 0; j < NumCoefs; j++) begin
      b_tab[j] = coef_q[RegBCoef01 + j / 2][(j % 2) * CoefW +: CoefW];
    end
    a_tab[0] = '0;
    for (int j = 1; j < NumCoefs; j++) begin
      a_tab[j] = coef_q[RegACoef12 + (j - 1) / 2][((j - 1) % 2) * CoefW +: CoefW];
    end
  end

  // ------------------------------------------------------------------
  // Sequencer
  // Step 0 multiplies b0 by the new sample. Odd step 2i-1 takes b_i times the
  // ring head's input, even step 2i takes a_i times the head's output and then
  // advances the ring by one cell. After ORDER advances the ring is back home.
  // ------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [StepW-1:0]        step_q, step_d;
  logic signed [SampleW-1:0] x_q, x_d;
  logic                    out_valid_q, out_valid_d;
  logic [SampleW-1:0]      out_data_q, out_data_d;
  logic                    out_sat_q, out_sat_d;
  logic                    out_free;
  logic                    load_out;
  cell_ctrl_t              cell_ctrl;
  mac_ctrl_t               mac_ctrl;

  logic [StepW:0]          step_inc;
  logic [CoefIdxW-1:0]     coef_idx;
  logic                    step_is_a;
  logic signed [CoefW-1:0] mul_coef;
  logic signed [HistW-1:0] mul_opnd;

  logic signed [SampleW-1:0] cell_x [ORDER];
  logic signed [HistW-1:0]   cell_y [ORDER];
  logic signed [AccW-1:0]    acc;
  logic signed [HistW-1:0]   y_new;
  logic [SampleW-1:0]        r_new;
  logic                      r_sat;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    x_d           = x_q;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    cell_ctrl     = '0;
    mac_ctrl      = '0;

    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          x_d            = s_axis_tdata;
          step_d         = '0;
          mac_ctrl.clear = 1'b1;
          state_d        = StMac;
        end
      end
      StMac: begin
        mac_ctrl.issue   = 1'b1;
        mac_ctrl.is_a    = step_is_a;
        cell_ctrl.rotate = step_is_a;
        if (step_q == LastStep) begin
          state_d = StDrain;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StDrain: begin
        // last product lands in the accumulator
        state_d = StRound;
      end
      StRound: begin
        // hold the finished sum until the output register can take it
        if (out_free) begin
          load_out        = 1'b1;
          cell_ctrl.shift = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // Operand selection for the shared multiplier
  assign step_inc  = {1'b0, step_q} + 1'b1;
  assign coef_idx  = CoefIdxW'(step_inc >> 1);
  assign step_is_a = (step_q != '0) && !step_q[0];

  always_comb begin
    if (step_is_a) begin
      mul_coef = a_tab[coef_idx];
      mul_opnd = cell_y[0];
    end else if (step_q == '0) begin
      mul_coef = b_tab[coef_idx];
      mul_opnd = HistW'(x_q);
    end else begin
      mul_coef = b_tab[coef_idx];
      mul_opnd = HistW'(cell_x[0]);
    end
  end

  iirdf1_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (mul_coef),
    .opnd_i (mul_opnd),
    .acc_o  (acc)
  );

  // ------------------------------------------------------------------
  // History ring. Cell 0 is the head and holds x[n-1], y[n-1].
  // ------------------------------------------------------------------
  for (genvar k = 0; k < ORDER; k++) begin : g_cell
    logic signed [SampleW-1:0] sh_x;
    logic signed [HistW-1:0]   sh_y;

    if (k == 0) begin : g_head
      assign sh_x = x_q;
      assign sh_y = y_new;
    end else begin : g_body
      assign sh_x = cell_x[k-1];
      assign sh_y = cell_y[k-1];
    end

    iirdf1_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .rot_x_i (cell_x[(k + 1) % ORDER]),
      .rot_y_i (cell_y[(k + 1) % ORDER]),
      .sh_x_i  (sh_x),
      .sh_y_i  (sh_y),
      .x_o     (cell_x[k]),
      .y_o     (cell_y[k])
    );
  end

  // ------------------------------------------------------------------
  // Round half up and saturate: Q16.16 feedback and 16-bit output.
  // ------------------------------------------------------------------
  logic signed [AccW-1:0]      rnd_y, rnd_r;
  logic [AccW-YShift-HistW:0]  y_top;
  logic [AccW-RShift-SampleW:0] r_top;
  logic                        y_fits, r_fits;

  assign rnd_y  = acc + (AccW'(1) << (YShift - 1));
  assign rnd_r  = acc + (AccW'(1) << (RShift - 1));
  assign y_top  = rnd_y[AccW-1:YShift+HistW-1];
  assign r_top  = rnd_r[AccW-1:RShift+SampleW-1];
  assign y_fits = (&y_top) || !(|y_top);
  assign r_fits = (&r_top) || !(|r_top);

  always_comb begin
    if (y_fits) begin
      y_new = rnd_y[YShift+HistW-1:YShift];
    end else begin
      y_new = rnd_y[AccW-1] ? {1'b1, {(HistW-1){1'b0}}} : {1'b0, {(HistW-1){1'b1}}};
    end
    if (r_fits) begin
      r_new = rnd_r[RShift+SampleW-1:RShift];
    end else begin
      r_new = rnd_r[AccW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end
    r_sat = !r_fits;
  end

  // ------------------------------------------------------------------
  // Output register: frees the input side while a result waits.
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_sat_d   = out_sat_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = r_new;
      out_sat_d   = r_sat;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_sat_q  <= out_sat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

endmodule
